>>> hw/rtl/kmuf_pkg.sv
// shared types, constants and helper functions of the kruskal maze union-find block
package kmuf_pkg;

	localparam int COORD_BITS = 8;
	localparam int SIDE = 1 << COORD_BITS;
	localparam int DIM_BITS = COORD_BITS + 1;
	localparam int FIELD_BITS = 8;
	localparam int CFG_BITS = 8;
	localparam int CMP_BITS = (DIM_BITS > FIELD_BITS) ? DIM_BITS : FIELD_BITS;
	localparam int ADDR_BITS = 2 * COORD_BITS;
	localparam int DEPTH = 1 << ADDR_BITS;
	localparam int REG_IDX_BITS = 1;
	localparam int CNT_BITS = 3;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [DIM_BITS-1:0] dim_t;
	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [FIELD_BITS-1:0] field_t;

	typedef enum logic {
		FUNC_BEGIN = 1'b0,
		FUNC_WALL  = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEARED  = 3'd0,
		ST_NOT_TWO  = 3'd1,
		ST_SAME_SET = 3'd2,
		ST_CARVED   = 3'd3,
		ST_REJECTED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		DIR_N = 2'd0,
		DIR_E = 2'd1,
		DIR_S = 2'd2,
		DIR_W = 2'd3
	} dir_t;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		FP_A = 2'd0,
		FP_B = 2'd1,
		FP_M = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_NB_RD,
		S_NB_CHK,
		S_FIND_RD,
		S_FIND_CHK,
		S_CARVE,
		S_LINK_B,
		S_LINK_M,
		S_DONE
	} state_t;

	typedef struct packed {
		func_t  func;
		field_t wall_x;
		field_t wall_y;
	} in_word_t;

	typedef struct packed {
		status_t status;
		field_t  cell_a_x;
		field_t  cell_a_y;
		field_t  cell_b_x;
		field_t  cell_b_y;
		field_t  carve_x;
		field_t  carve_y;
	} out_word_t;

	typedef struct packed {
		addr_t addr;
		logic  wall_we;
		logic  wall_wd;
		logic  par_we;
		addr_t par_wd;
	} mem_req_t;

	function automatic addr_t cell_addr(input coord_t x, input coord_t y);
		return {y, x};
	endfunction

	function automatic field_t to_field(input coord_t v);
		logic [CMP_BITS-1:0] t;
		t = CMP_BITS'(v);
		return t[FIELD_BITS-1:0];
	endfunction

	function automatic coord_t from_field(input field_t v);
		logic [CMP_BITS-1:0] t;
		t = CMP_BITS'(v);
		return t[COORD_BITS-1:0];
	endfunction

	function automatic dim_t eff_dim(input logic [CFG_BITS-1:0] r);
		logic [CMP_BITS-1:0] t;
		t = CMP_BITS'(r);
		if (t < CMP_BITS'(SIDE)) begin
			return t[DIM_BITS-1:0];
		end
		return DIM_BITS'(SIDE);
	endfunction

endpackage

>>> hw/rtl/kmuf_cell_mem.sv
// cell store: wall bit and parent link per cell, one address, registered read
module kmuf_cell_mem (
	input  logic               clk,
	input  kmuf_pkg::mem_req_t req,
	output logic               rd_wall,
	output kmuf_pkg::addr_t    rd_par
);

	logic            wall_mem [0:kmuf_pkg::DEPTH-1];
	kmuf_pkg::addr_t par_mem  [0:kmuf_pkg::DEPTH-1];

	always_ff @(posedge clk) begin
		if (req.wall_we) begin
			wall_mem[req.addr] <= req.wall_wd;
		end
		rd_wall <= wall_mem[req.addr];
	end

	always_ff @(posedge clk) begin
		if (req.par_we) begin
			par_mem[req.addr] <= req.par_wd;
		end
		rd_par <= par_mem[req.addr];
	end

endmodule

>>> hw/rtl/kmuf_nbr_unit.sv
// shared neighbour unit: candidate coordinates and grid check for one direction
module kmuf_nbr_unit (
	input  kmuf_pkg::coord_t x,
	input  kmuf_pkg::coord_t y,
	input  kmuf_pkg::dir_t   dir,
	input  kmuf_pkg::dim_t   w,
	input  kmuf_pkg::dim_t   h,
	output kmuf_pkg::coord_t cx,
	output kmuf_pkg::coord_t cy,
	output logic             ok
);

	kmuf_pkg::dim_t xp1;
	kmuf_pkg::dim_t yp1;

	assign xp1 = kmuf_pkg::DIM_BITS'(x) + kmuf_pkg::DIM_BITS'(1);
	assign yp1 = kmuf_pkg::DIM_BITS'(y) + kmuf_pkg::DIM_BITS'(1);

	always_comb begin
		cx = x;
		cy = y;
		ok = 1'b0;
		case (dir)
			kmuf_pkg::DIR_N: begin
				ok = (y != '0);
				cy = y - kmuf_pkg::COORD_BITS'(1);
			end
			kmuf_pkg::DIR_E: begin
				ok = (xp1 < w);
				cx = xp1[kmuf_pkg::COORD_BITS-1:0];
			end
			kmuf_pkg::DIR_S: begin
				ok = (yp1 < h);
				cy = yp1[kmuf_pkg::COORD_BITS-1:0];
			end
			kmuf_pkg::DIR_W: begin
				ok = (x != '0);
				cx = x - kmuf_pkg::COORD_BITS'(1);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

endmodule

>>> hw/rtl/kruskal_maze_union_find_top.sv
// top level of the kruskal maze union-find block: sequencer and datapath registers
//
// usage: pulse start with a command word on cmd while busy is low. func begin
// rewrites every cell of the grid set by grid_width and grid_height; func wall
// offers one wall cell. exactly one result word appears on result for one
// cycle, marked by done; the receiver cannot hold it off. busy stays high
// from the accepted command until the cycle after done.
// configuration: cfg_we with cfg_index and cfg_wdata writes one register;
// the user must write only while busy is low, the block does not enforce it.
// sequence after accept: begin clears one cell per cycle; a rejected wall goes
// straight to done; a scanned wall reads its neighbours (S_NB_RD, S_NB_CHK per
// direction, one cell store read each); with two open ones each root walk reads
// one chain link per S_FIND_RD, S_FIND_CHK pair; if the roots differ, S_CARVE
// opens the cell and S_LINK_B, S_LINK_M write the links; S_DONE gives the result.
// the single port of the cell store sets this order; one command at a time.
// reset: sequencer returns to idle, grid registers to 11 by 11; the cell
// store holds nothing valid until a begin command has swept it.
module kruskal_maze_union_find_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  kmuf_pkg::in_word_t                  cmd,
	output logic                                busy,
	output logic                                done,
	output kmuf_pkg::out_word_t                 result,
	input  logic                                cfg_we,
	input  logic [kmuf_pkg::REG_IDX_BITS-1:0]   cfg_index,
	input  logic [kmuf_pkg::CFG_BITS-1:0]       cfg_wdata
);

	kmuf_pkg::state_t state_q, state_d;
	logic [kmuf_pkg::CFG_BITS-1:0] gw_q, gh_q;
	kmuf_pkg::dim_t w, h;

	kmuf_pkg::dir_t   dir_q;
	logic [kmuf_pkg::CNT_BITS-1:0] cnt_q, cnt_n;
	kmuf_pkg::phase_t phase_q;
	kmuf_pkg::addr_t  steps_q;

	kmuf_pkg::status_t status_q;
	kmuf_pkg::coord_t  x_q, y_q, ax_q, ay_q, bx_q, by_q, mx_q, my_q, sx_q, sy_q;
	kmuf_pkg::addr_t   idx_q, ra_q, rb_q, rm_q;

	kmuf_pkg::coord_t  cand_x, cand_y;
	logic              cand_ok;
	kmuf_pkg::mem_req_t mreq;
	logic              rd_wall;
	kmuf_pkg::addr_t   rd_par;

	logic accept, reject, empty, last_x, last_y, hit, root_stop, is_root;
	kmuf_pkg::addr_t  root;
	kmuf_pkg::dim_t   sum_x, sum_y;
	kmuf_pkg::coord_t mid_x_c, mid_y_c;

	assign w = kmuf_pkg::eff_dim(gw_q);
	assign h = kmuf_pkg::eff_dim(gh_q);

	kmuf_nbr_unit u_nbr (
		.x   (x_q),
		.y   (y_q),
		.dir (dir_q),
		.w   (w),
		.h   (h),
		.cx  (cand_x),
		.cy  (cand_y),
		.ok  (cand_ok)
	);

	kmuf_cell_mem u_mem (
		.clk     (clk),
		.req     (mreq),
		.rd_wall (rd_wall),
		.rd_par  (rd_par)
	);

	assign accept = start && (state_q == kmuf_pkg::S_IDLE);
	assign reject = (kmuf_pkg::CMP_BITS'(cmd.wall_x) >= kmuf_pkg::CMP_BITS'(w))
		|| (kmuf_pkg::CMP_BITS'(cmd.wall_y) >= kmuf_pkg::CMP_BITS'(h))
		|| !(cmd.wall_x[0] || cmd.wall_y[0]);
	assign empty = (w == '0) || (h == '0);
	assign last_x = (kmuf_pkg::DIM_BITS'(sx_q) == (w - kmuf_pkg::DIM_BITS'(1)));
	assign last_y = (kmuf_pkg::DIM_BITS'(sy_q) == (h - kmuf_pkg::DIM_BITS'(1)));
	assign hit = cand_ok && !rd_wall;
	assign cnt_n = cnt_q + kmuf_pkg::CNT_BITS'(hit);
	assign is_root = (rd_par == idx_q);
	assign root_stop = is_root || (steps_q == kmuf_pkg::ADDR_BITS'(kmuf_pkg::DEPTH - 1));
	assign root = is_root ? idx_q : rd_par;

	assign sum_x = kmuf_pkg::DIM_BITS'(ax_q) + kmuf_pkg::DIM_BITS'(bx_q);
	assign sum_y = kmuf_pkg::DIM_BITS'(ay_q) + kmuf_pkg::DIM_BITS'(by_q);
	assign mid_x_c = (ax_q == bx_q) ? ax_q : sum_x[kmuf_pkg::DIM_BITS-1:1];
	assign mid_y_c = (ax_q == bx_q) ? sum_y[kmuf_pkg::DIM_BITS-1:1] : ay_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kmuf_pkg::S_IDLE: begin
				if (accept) begin
					if (cmd.func == kmuf_pkg::FUNC_BEGIN) begin
						state_d = empty ? kmuf_pkg::S_DONE : kmuf_pkg::S_CLEAR;
					end else begin
						state_d = reject ? kmuf_pkg::S_DONE : kmuf_pkg::S_NB_RD;
					end
				end
			end
			kmuf_pkg::S_CLEAR: begin
				if (last_x && last_y) begin
					state_d = kmuf_pkg::S_DONE;
				end
			end
			kmuf_pkg::S_NB_RD: begin
				state_d = kmuf_pkg::S_NB_CHK;
			end
			kmuf_pkg::S_NB_CHK: begin
				if (dir_q == kmuf_pkg::DIR_W) begin
					state_d = (cnt_n == kmuf_pkg::CNT_BITS'(2)) ? kmuf_pkg::S_FIND_RD
						: kmuf_pkg::S_DONE;
				end else begin
					state_d = kmuf_pkg::S_NB_RD;
				end
			end
			kmuf_pkg::S_FIND_RD: begin
				state_d = kmuf_pkg::S_FIND_CHK;
			end
			kmuf_pkg::S_FIND_CHK: begin
				state_d = kmuf_pkg::S_FIND_RD;
				if (root_stop) begin
					case (phase_q)
						kmuf_pkg::FP_A: state_d = kmuf_pkg::S_FIND_RD;
						kmuf_pkg::FP_B: begin
							state_d = (root == ra_q) ? kmuf_pkg::S_DONE : kmuf_pkg::S_CARVE;
						end
						kmuf_pkg::FP_M: state_d = kmuf_pkg::S_LINK_B;
						default: state_d = kmuf_pkg::S_DONE;
					endcase
				end
			end
			kmuf_pkg::S_CARVE: begin
				state_d = kmuf_pkg::S_FIND_RD;
			end
			kmuf_pkg::S_LINK_B: begin
				state_d = kmuf_pkg::S_LINK_M;
			end
			kmuf_pkg::S_LINK_M: begin
				state_d = kmuf_pkg::S_DONE;
			end
			kmuf_pkg::S_DONE: begin
				state_d = kmuf_pkg::S_IDLE;
			end
			default: begin
				state_d = kmuf_pkg::S_IDLE;
			end
		endcase
	end

	// cell store requests and handshake outputs
	always_comb begin
		mreq.addr = idx_q;
		mreq.wall_we = 1'b0;
		mreq.wall_wd = 1'b0;
		mreq.par_we = 1'b0;
		mreq.par_wd = ra_q;
		case (state_q)
			kmuf_pkg::S_CLEAR: begin
				mreq.addr = kmuf_pkg::cell_addr(sx_q, sy_q);
				mreq.wall_we = 1'b1;
				mreq.wall_wd = sx_q[0] | sy_q[0];
				mreq.par_we = 1'b1;
				mreq.par_wd = kmuf_pkg::cell_addr(sx_q, sy_q);
			end
			kmuf_pkg::S_NB_RD: begin
				mreq.addr = kmuf_pkg::cell_addr(cand_x, cand_y);
			end
			kmuf_pkg::S_CARVE: begin
				mreq.addr = kmuf_pkg::cell_addr(mx_q, my_q);
				mreq.wall_we = 1'b1;
			end
			kmuf_pkg::S_LINK_B: begin
				mreq.addr = rb_q;
				mreq.par_we = 1'b1;
			end
			kmuf_pkg::S_LINK_M: begin
				mreq.addr = rm_q;
				mreq.par_we = 1'b1;
			end
			default: begin
				mreq.addr = idx_q;
			end
		endcase
	end

	assign busy = (state_q != kmuf_pkg::S_IDLE);
	assign done = (state_q == kmuf_pkg::S_DONE);

	assign result.status = status_q;
	assign result.cell_a_x = kmuf_pkg::to_field(ax_q);
	assign result.cell_a_y = kmuf_pkg::to_field(ay_q);
	assign result.cell_b_x = kmuf_pkg::to_field(bx_q);
	assign result.cell_b_y = kmuf_pkg::to_field(by_q);
	assign result.carve_x = kmuf_pkg::to_field(mx_q);
	assign result.carve_y = kmuf_pkg::to_field(my_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kmuf_pkg::S_IDLE;
			gw_q <= kmuf_pkg::CFG_BITS'(11);
			gh_q <= kmuf_pkg::CFG_BITS'(11);
			dir_q <= kmuf_pkg::DIR_N;
			cnt_q <= '0;
			phase_q <= kmuf_pkg::FP_A;
			steps_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (kmuf_pkg::reg_idx_t'(cfg_index))
					kmuf_pkg::REG_GRID_WIDTH: gw_q <= cfg_wdata;
					kmuf_pkg::REG_GRID_HEIGHT: gh_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				kmuf_pkg::S_IDLE: begin
					if (accept) begin
						dir_q <= kmuf_pkg::DIR_N;
						cnt_q <= '0;
						phase_q <= kmuf_pkg::FP_A;
						steps_q <= '0;
					end
				end
				kmuf_pkg::S_NB_CHK: begin
					dir_q <= kmuf_pkg::dir_t'(dir_q + 2'd1);
					cnt_q <= cnt_n;
					steps_q <= '0;
				end
				kmuf_pkg::S_FIND_CHK: begin
					if (root_stop) begin
						steps_q <= '0;
						case (phase_q)
							kmuf_pkg::FP_A: phase_q <= kmuf_pkg::FP_B;
							kmuf_pkg::FP_B: phase_q <= kmuf_pkg::FP_M;
							default: phase_q <= phase_q;
						endcase
					end else begin
						steps_q <= steps_q + kmuf_pkg::ADDR_BITS'(1);
					end
				end
				kmuf_pkg::S_CARVE: begin
					steps_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			kmuf_pkg::S_IDLE: begin
				if (accept) begin
					if (cmd.func == kmuf_pkg::FUNC_BEGIN) begin
						status_q <= kmuf_pkg::ST_CLEARED;
					end else if (reject) begin
						status_q <= kmuf_pkg::ST_REJECTED;
					end else begin
						status_q <= kmuf_pkg::ST_NOT_TWO;
					end
					x_q <= kmuf_pkg::from_field(cmd.wall_x);
					y_q <= kmuf_pkg::from_field(cmd.wall_y);
					ax_q <= '0;
					ay_q <= '0;
					bx_q <= '0;
					by_q <= '0;
					mx_q <= '0;
					my_q <= '0;
					sx_q <= '0;
					sy_q <= '0;
				end
			end
			kmuf_pkg::S_CLEAR: begin
				if (last_x) begin
					sx_q <= '0;
					sy_q <= sy_q + kmuf_pkg::COORD_BITS'(1);
				end else begin
					sx_q <= sx_q + kmuf_pkg::COORD_BITS'(1);
				end
			end
			kmuf_pkg::S_NB_CHK: begin
				if (hit && (cnt_q == kmuf_pkg::CNT_BITS'(0))) begin
					ax_q <= cand_x;
					ay_q <= cand_y;
				end
				if (hit && (cnt_q == kmuf_pkg::CNT_BITS'(1))) begin
					bx_q <= cand_x;
					by_q <= cand_y;
				end
				idx_q <= kmuf_pkg::cell_addr(ax_q, ay_q);
			end
			kmuf_pkg::S_FIND_CHK: begin
				if (root_stop) begin
					case (phase_q)
						kmuf_pkg::FP_A: begin
							ra_q <= root;
							idx_q <= kmuf_pkg::cell_addr(bx_q, by_q);
						end
						kmuf_pkg::FP_B: begin
							rb_q <= root;
							if (root == ra_q) begin
								status_q <= kmuf_pkg::ST_SAME_SET;
							end else begin
								mx_q <= mid_x_c;
								my_q <= mid_y_c;
							end
						end
						kmuf_pkg::FP_M: begin
							rm_q <= root;
							status_q <= kmuf_pkg::ST_CARVED;
						end
						default: ;
					endcase
				end else begin
					idx_q <= rd_par;
				end
			end
			kmuf_pkg::S_CARVE: begin
				idx_q <= kmuf_pkg::cell_addr(mx_q, my_q);
			end
			default: ;
		endcase
	end

endmodule

>>> sim/kruskal_maze_union_find_top_tb.sv
// testbench for the kruskal maze union-find block: random mazes checked against a predictor
`timescale 1ns / 1ps

module kruskal_maze_union_find_top_tb;
	import kmuf_pkg::*;

	localparam int STALL_LIMIT = 250000;
	localparam int ITEM_TARGET = 750;

	class carve_scoreboard;
		bit                 wall_map [DEPTH];
		bit [ADDR_BITS-1:0] parent_link [DEPTH];
		int unsigned        grid_w = 11;
		int unsigned        grid_h = 11;
		out_word_t          owed[$];
		int                 mismatches = 0;
		int                 results_seen = 0;

		task report(string msg);
			mismatches++;
			$display("%0t: mismatch on result %0d: %s", $time, results_seen, msg);
		endtask

		function void set_reg(reg_idx_t idx, int unsigned v);
			case (idx)
				REG_GRID_WIDTH: begin
					grid_w = v;
				end
				REG_GRID_HEIGHT: begin
					grid_h = v;
				end
				default: ;
			endcase
		endfunction

		function addr_t cell_of(int unsigned x, int unsigned y);
			return addr_t'((y << COORD_BITS) | x);
		endfunction

		function addr_t root_of(addr_t a);
			int unsigned steps;
			steps = 0;
			while (steps < DEPTH && parent_link[a] != a) begin
				a = parent_link[a];
				steps++;
			end
			return a;
		endfunction

		function void note_command(in_word_t w);
			out_word_t   r;
			int unsigned gw, gh, x, y, cnt, mx, my;
			int unsigned ax[2], ay[2], cx[4], cy[4];
			bit          ok[4];
			addr_t       ra, rb, rm, mid;
			r = '0;
			gw = (grid_w < SIDE) ? grid_w : SIDE;
			gh = (grid_h < SIDE) ? grid_h : SIDE;
			x = w.wall_x;
			y = w.wall_y;
			if (w.func == FUNC_BEGIN) begin
				for (int yy = 0; yy < gh; yy++) begin
					for (int xx = 0; xx < gw; xx++) begin
						wall_map[cell_of(xx, yy)] = ((xx | yy) & 1) != 0;
						parent_link[cell_of(xx, yy)] = cell_of(xx, yy);
					end
				end
				r.status = ST_CLEARED;
			end else if (x >= gw || y >= gh || ((x | y) & 1) == 0) begin
				r.status = ST_REJECTED;
			end else begin
				ok[DIR_N] = y > 0;
				cx[DIR_N] = x;
				cy[DIR_N] = (y > 0) ? y - 1 : 0;
				ok[DIR_E] = x + 1 < gw;
				cx[DIR_E] = x + 1;
				cy[DIR_E] = y;
				ok[DIR_S] = y + 1 < gh;
				cx[DIR_S] = x;
				cy[DIR_S] = y + 1;
				ok[DIR_W] = x > 0;
				cx[DIR_W] = (x > 0) ? x - 1 : 0;
				cy[DIR_W] = y;
				cnt = 0;
				ax = '{0, 0};
				ay = '{0, 0};
				for (int i = 0; i < 4; i++) begin
					if (ok[i] && !wall_map[cell_of(cx[i], cy[i])]) begin
						if (cnt < 2) begin
							ax[cnt] = cx[i];
							ay[cnt] = cy[i];
						end
						cnt++;
					end
				end
				r.cell_a_x = field_t'(ax[0]);
				r.cell_a_y = field_t'(ay[0]);
				r.cell_b_x = field_t'(ax[1]);
				r.cell_b_y = field_t'(ay[1]);
				if (cnt != 2) begin
					r.status = ST_NOT_TWO;
				end else begin
					ra = root_of(cell_of(ax[0], ay[0]));
					rb = root_of(cell_of(ax[1], ay[1]));
					if (ra == rb) begin
						r.status = ST_SAME_SET;
					end else begin
						if (ax[0] == ax[1]) begin
							mx = ax[0];
							my = (ay[0] + ay[1]) >> 1;
						end else begin
							mx = (ax[0] + ax[1]) >> 1;
							my = ay[0];
						end
						mid = cell_of(mx, my);
						wall_map[mid] = 1'b0;
						rm = root_of(mid);
						parent_link[rb] = ra;
						parent_link[rm] = ra;
						r.status = ST_CARVED;
						r.carve_x = field_t'(mx);
						r.carve_y = field_t'(my);
					end
				end
			end
			owed = {owed, r};
		endfunction

		task cmp_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want) begin
				report($sformatf("%s got %0h want %0h", name, got, want));
			end
		endtask

		task check_result(out_word_t got);
			out_word_t want;
			results_seen++;
			if (owed.size() == 0) begin
				report("result word with none due");
				return;
			end
			want = owed.pop_front();
			cmp_field("status", 8'(got.status), 8'(want.status));
			cmp_field("cell_a_x", got.cell_a_x, want.cell_a_x);
			cmp_field("cell_a_y", got.cell_a_y, want.cell_a_y);
			cmp_field("cell_b_x", got.cell_b_x, want.cell_b_x);
			cmp_field("cell_b_y", got.cell_b_y, want.cell_b_y);
			cmp_field("carve_x", got.carve_x, want.carve_x);
			cmp_field("carve_y", got.carve_y, want.carve_y);
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	in_word_t                cmd = '0;
	logic                    busy;
	logic                    done;
	out_word_t               result;
	logic                    cfg_we = 1'b0;
	logic [REG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0]     cfg_wdata = '0;

	carve_scoreboard sb = new();
	int unsigned     cur_w = 11;
	int unsigned     cur_h = 11;
	bit              burst = 1'b0;
	int              items_sent = 0;

	kruskal_maze_union_find_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(result);
		end
	end

	function automatic in_word_t word_of(func_t f, int unsigned x, int unsigned y);
		in_word_t w;
		w.func = f;
		w.wall_x = field_t'(x);
		w.wall_y = field_t'(y);
		return w;
	endfunction

	// hold start across back-to-back words so it never drops and rises in one step
	task automatic send_word(in_word_t w);
		int unsigned gap;
		bit          settle;
		gap = burst ? 0 : $urandom_range(4, 0);
		settle = burst ? 1'b0 : 1'($urandom_range(1, 0));
		if (gap != 0 || settle) begin
			start <= 1'b0;
		end
		if (settle) begin
			do @(posedge clk); while (busy);
		end
		repeat (gap) @(posedge clk);
		start <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (busy);
		sb.note_command(w);
		items_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.owed.size() != 0 || busy);
	endtask

	task automatic set_grid(int unsigned w, int unsigned h);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_wdata <= CFG_BITS'(w);
		@(posedge clk);
		sb.set_reg(REG_GRID_WIDTH, w);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_wdata <= CFG_BITS'(h);
		@(posedge clk);
		sb.set_reg(REG_GRID_HEIGHT, h);
		cfg_we <= 1'b0;
		cur_w = w;
		cur_h = h;
		send_word(word_of(FUNC_BEGIN, $urandom_range(255, 0), $urandom_range(255, 0)));
	endtask

	function automatic in_word_t noise_word();
		case ($urandom_range(3, 0))
			0: return word_of(FUNC_WALL, $urandom_range(255, 0), $urandom_range(255, 0));
			1: return word_of(FUNC_WALL, $urandom_range((cur_w - 1) / 2, 0) * 2 + 1,
				$urandom_range((cur_h - 1) / 2, 0) * 2 + 1);
			2: return word_of(FUNC_WALL, $urandom_range((cur_w - 1) / 2, 0) * 2,
				$urandom_range((cur_h - 1) / 2, 0) * 2);
			default: return word_of(FUNC_WALL, $urandom_range(255, cur_w),
				$urandom_range(255, 0));
		endcase
	endfunction

	// shuffled walls of one region, a cut of them offered, noise mixed in
	task automatic carve_region(int unsigned x0, int unsigned y0, int unsigned x1,
			int unsigned y1, int unsigned pct);
		in_word_t    walls[$];
		in_word_t    t;
		int unsigned j, keep;
		burst = ($urandom_range(3, 0) == 0);
		for (int unsigned y = y0; y <= y1; y++) begin
			for (int unsigned x = x0; x <= x1; x++) begin
				if (((x ^ y) & 1) == 1) begin
					walls = {walls, word_of(FUNC_WALL, x, y)};
				end
			end
		end
		for (int i = walls.size() - 1; i > 0; i--) begin
			j = $urandom_range(i, 0);
			t = walls[i];
			walls[i] = walls[j];
			walls[j] = t;
		end
		keep = walls.size() * pct / 100;
		for (int i = 0; i < keep; i++) begin
			if ($urandom_range(9, 0) == 0) begin
				send_word(noise_word());
			end
			if (cur_w * cur_h < 1000 && $urandom_range(59, 0) == 0) begin
				send_word(word_of(FUNC_BEGIN, $urandom_range(255, 0), $urandom_range(255, 0)));
			end
			send_word(walls[i]);
		end
		burst = 1'b0;
	endtask

	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (arst_n && ((start && !busy) || done)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("** kruskal_maze_union_find_top: FAILED **");
		$finish;
	end

	initial begin
		int unsigned w, h;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset grid of 11 by 11
		send_word(word_of(FUNC_BEGIN, 255, 0));
		send_word(word_of(FUNC_WALL, 2, 2));
		send_word(word_of(FUNC_WALL, 0, 0));
		send_word(word_of(FUNC_WALL, 11, 1));
		send_word(word_of(FUNC_WALL, 1, 200));
		send_word(word_of(FUNC_WALL, 255, 255));
		send_word(word_of(FUNC_WALL, 3, 3));
		send_word(word_of(FUNC_WALL, 1, 0));
		send_word(word_of(FUNC_WALL, 1, 0));
		send_word(word_of(FUNC_WALL, 1, 1));
		send_word(word_of(FUNC_WALL, 0, 1));
		send_word(word_of(FUNC_WALL, 2, 1));
		send_word(word_of(FUNC_WALL, 1, 1));
		send_word(word_of(FUNC_WALL, 1, 2));
		send_word(word_of(FUNC_WALL, 10, 9));
		send_word(word_of(FUNC_WALL, 9, 10));
		send_word(word_of(FUNC_WALL, 9, 9));
		send_word(word_of(FUNC_WALL, 10, 1));
		send_word(word_of(FUNC_BEGIN, 170, 85));
		send_word(word_of(FUNC_WALL, 1, 0));
		send_word(word_of(FUNC_WALL, 0, 1));

		// extremes of the grid
		set_grid(255, 255);
		send_word(word_of(FUNC_WALL, 254, 253));
		send_word(word_of(FUNC_WALL, 253, 254));
		send_word(word_of(FUNC_WALL, 254, 255));
		carve_region(243, 243, 254, 254, 100);
		carve_region(0, 0, 8, 8, 100);
		set_grid(255, 11);
		carve_region(240, 0, 254, 10, 60);
		set_grid(11, 255);
		carve_region(0, 240, 10, 254, 60);
		set_grid(12, 14);
		carve_region(0, 0, 11, 13, 100);

		while (items_sent < ITEM_TARGET) begin
			w = $urandom_range(25, 11);
			h = $urandom_range(25, 11);
			if ($urandom_range(3, 0) != 0) begin
				w = w | 1;
				h = h | 1;
			end
			set_grid(w, h);
			carve_region(0, 0, w - 1, h - 1, $urandom_range(100, 70));
		end

		drain();
		repeat (16) @(posedge clk);
		if (sb.owed.size() != 0) begin
			sb.report("results still due at end of run");
		end
		if (sb.mismatches == 0) begin
			$display("** kruskal_maze_union_find_top: PASSED **");
		end else begin
			$display("** kruskal_maze_union_find_top: FAILED **");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/kmuf_pkg.sv
hw/rtl/kmuf_cell_mem.sv
hw/rtl/kmuf_nbr_unit.sv
hw/rtl/kruskal_maze_union_find_top.sv
sim/kruskal_maze_union_find_top_tb.sv
